/* hw/rtl/pdc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Packet deframer package
// Shared constants, byte role and status codes for the packet deframer.
// ----------------------------------------------------------------------------
package pdc_pkg;

   localparam int MAX_PACKET_BYTES_DEF = 64;

   localparam logic [7:0] SYNC_MASK   = 8'hF0;
   localparam logic [7:0] LENGTH_FLAG = 8'h01;

   typedef enum logic [2:0] {
      ROLE_HEADER   = 3'd0,
      ROLE_LENGTH   = 3'd1,
      ROLE_PAYLOAD  = 3'd2,
      ROLE_CHECKSUM = 3'd3,
      ROLE_DROPPED  = 3'd4
   } role_type;

   typedef enum logic [2:0] {
      STAT_BUSY     = 3'd0,
      STAT_GOOD     = 3'd1,
      STAT_BAD_SUM  = 3'd2,
      STAT_REJECTED = 3'd3,
      STAT_OVERFLOW = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      role_type   byte_role;
      logic [5:0] payload_index;
      logic [7:0] payload_length;
      status_type status;
   } rsp_word_type;

endpackage
`default_nettype wire

/* hw/rtl/pdc_intf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Packet deframer channels
// Valid/ready channels for received bytes, judged words and the sync register.
// ----------------------------------------------------------------------------
interface pdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pdc_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [7:0]           data_byte;
   pdc_pkg::role_type    byte_role;
   logic [5:0]           payload_index;
   logic [7:0]           payload_length;
   pdc_pkg::status_type  status;

   modport source (output valid, output data_byte, output byte_role,
                   output payload_index, output payload_length, output status,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_role,
                   input payload_index, input payload_length, input status,
                   output ready);
endinterface

interface pdc_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] sync_nibble;

   modport source (output valid, output sync_nibble, input ready);
   modport sink   (input valid, input sync_nibble, output ready);
endinterface
`default_nettype wire

/* hw/rtl/packet_deframer_with_checksum.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Packet deframer with checksum
// Judges each received byte against the packet framing and running sum.
// ----------------------------------------------------------------------------
// Takes one received byte per clock and returns one word per byte in the
// cycle after it is accepted: the byte, its role, its payload index, the packet's
// payload length and a status. Framing state and the 8-bit running sum are
// updated in a single pass at acceptance; the result lands in an output
// register, so a new byte is taken in every cycle in which that register is
// empty or being read. Packets longer than MAX_PACKET_BYTES minus one bytes
// are dropped and the next byte is taken as a header.
module packet_deframer_with_checksum #(
   parameter int MAX_PACKET_BYTES = pdc_pkg::MAX_PACKET_BYTES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   pdc_req_if.sink   req,
   pdc_rsp_if.source rsp,
   pdc_csr_if.sink   csr
);
   import pdc_pkg::*;

   localparam int PosW = $clog2(MAX_PACKET_BYTES);
   localparam logic [8:0] LAST_POS = 9'(MAX_PACKET_BYTES - 1);

   logic [3:0]      sync_nibble_ff;
   logic [PosW-1:0] byte_position_ff, byte_position_in;
   logic            has_length_ff, has_length_in;
   logic [7:0]      length_seen_ff, length_seen_in;
   logic [7:0]      running_sum_ff, running_sum_in;
   logic            rsp_valid_ff;
   rsp_word_type    rsp_word_ff, rsp_word_in;

   logic       accept;
   logic [8:0] pos9, pay_start, cks_pos, pay_offset;
   logic [7:0] b, sum_add;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign b          = req.rx_byte;
   assign pos9       = 9'(byte_position_ff);
   assign pay_start  = 9'(has_length_ff) + 9'd1;
   assign cks_pos    = 9'(length_seen_ff) + pay_start;
   assign pay_offset = pos9 - pay_start;
   assign sum_add    = running_sum_ff + b;

   always_comb begin
      byte_position_in           = PosW'(pos9 + 9'd1);
      has_length_in              = has_length_ff;
      length_seen_in             = length_seen_ff;
      running_sum_in             = sum_add;
      rsp_word_in.data_byte      = b;
      rsp_word_in.byte_role      = ROLE_DROPPED;
      rsp_word_in.payload_index  = '0;
      rsp_word_in.payload_length = length_seen_ff;
      rsp_word_in.status         = STAT_BUSY;
      if (pos9 >= LAST_POS) begin
         byte_position_in           = '0;
         has_length_in              = 1'b0;
         length_seen_in             = '0;
         running_sum_in             = '0;
         rsp_word_in.payload_length = '0;
         rsp_word_in.status         = STAT_OVERFLOW;
      end else if (pos9 == 9'd0) begin
         rsp_word_in.byte_role      = ROLE_HEADER;
         rsp_word_in.payload_length = '0;
         if ((b & SYNC_MASK) == {sync_nibble_ff, 4'h0}) begin
            has_length_in  = (b & LENGTH_FLAG) != 8'h00;
            length_seen_in = '0;
            running_sum_in = b;
         end else begin
            byte_position_in   = '0;
            has_length_in      = 1'b0;
            length_seen_in     = '0;
            running_sum_in     = '0;
            rsp_word_in.status = STAT_REJECTED;
         end
      end else if (has_length_ff && pos9 == 9'd1) begin
         rsp_word_in.byte_role      = ROLE_LENGTH;
         rsp_word_in.payload_length = b;
         length_seen_in             = b;
      end else if (pos9 >= pay_start && pos9 < cks_pos) begin
         rsp_word_in.byte_role     = ROLE_PAYLOAD;
         rsp_word_in.payload_index = pay_offset[5:0];
      end else if (pos9 == cks_pos) begin
         rsp_word_in.byte_role = ROLE_CHECKSUM;
         rsp_word_in.status    = (running_sum_ff == b) ? STAT_GOOD : STAT_BAD_SUM;
         byte_position_in      = '0;
         has_length_in         = 1'b0;
         length_seen_in        = '0;
         running_sum_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_nibble_ff   <= '0;
         byte_position_ff <= '0;
         has_length_ff    <= 1'b0;
         length_seen_ff   <= '0;
         running_sum_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr.valid) begin
            sync_nibble_ff <= csr.sync_nibble;
         end
         if (accept) begin
            byte_position_ff <= byte_position_in;
            has_length_ff    <= has_length_in;
            length_seen_ff   <= length_seen_in;
            running_sum_ff   <= running_sum_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.data_byte      = rsp_word_ff.data_byte;
   assign rsp.byte_role      = rsp_word_ff.byte_role;
   assign rsp.payload_index  = rsp_word_ff.payload_index;
   assign rsp.payload_length = rsp_word_ff.payload_length;
   assign rsp.status         = rsp_word_ff.status;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos9 <= LAST_POS)
      else $error("byte position beyond packet limit");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_word_in.status != STAT_BUSY
      |=> byte_position_ff == '0 && running_sum_ff == '0 && !has_length_ff)
      else $error("packet state not cleared after packet end");

   a_drop_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status == STAT_OVERFLOW
      |-> rsp_word_ff.byte_role == ROLE_DROPPED && rsp_word_ff.payload_length == 8'h00)
      else $error("overflow drop word carries packet fields");

   a_index_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.byte_role != ROLE_PAYLOAD
      |-> rsp_word_ff.payload_index == 6'd0)
      else $error("payload index set on non-payload word");

endmodule
`default_nettype wire
